// File: hw/rtl/mm_pkg.sv
// mm_pkg: shared types and constants for the matrix multiply block
// no dependencies; imported by every module of the block but mm_ram
package mm_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int ELEM_BITS_DEF = 16;
  localparam int VALUE_BITS    = 16;
  localparam int SUM_BITS      = 36;
  localparam int IDX_BITS      = 3;
  localparam int CFG_BITS      = 4;
  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;
  localparam int IN_DATA_BITS  = 24;
  localparam int OUT_DATA_BITS = 48;

  typedef enum logic [1:0] {
    ACT_WRITE_A  = 2'd0,
    ACT_WRITE_B  = 2'd1,
    ACT_MULTIPLY = 2'd2
  } mm_action_t;

  typedef enum logic [1:0] {
    REG_ROWS_A     = 2'd0,
    REG_INNER_SIZE = 2'd1,
    REG_COLS_B     = 2'd2
  } mm_reg_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } mm_state_t;

  // start command: sizes already clamped, held as size minus one
  typedef struct packed {
    logic                start;
    logic [CFG_BITS-1:0] rows_m1;
    logic [CFG_BITS-1:0] inner_m1;
    logic [CFG_BITS-1:0] cols_m1;
  } mm_cmd_t;

  typedef struct packed {
    logic                valid;
    logic                first;
    logic                last_k;
    logic                last_out;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
  } mm_tag_t;

endpackage

// File: hw/rtl/mm_ram.sv
// mm_ram: generic single-write, single-read memory with registered read
// no dependencies
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/mm_engine.sv
// mm_engine: walks i, j, k over the element memories and accumulates dot products
// depends on mm_pkg; drives read ports of two mm_ram instances in the top level
module mm_engine
  import mm_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mm_cmd_t                              cmd,
  output logic                                 busy,
  output logic                                 rd_en,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   rd_addr_a,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   rd_addr_b,
  input  logic [ELEM_BITS-1:0]                 rd_data_a,
  input  logic [ELEM_BITS-1:0]                 rd_data_b,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [IDX_BITS-1:0]                  out_row,
  output logic [IDX_BITS-1:0]                  out_col,
  output logic [SUM_BITS-1:0]                  out_sum,
  output logic                                 out_last
);

  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int ADDR_W    = $clog2(MAX_DIM*MAX_DIM);
  localparam int PROD_BITS = 2 * ELEM_BITS;
  localparam int EXT_BITS  = (PROD_BITS > SUM_BITS) ? PROD_BITS : SUM_BITS;

  mm_state_t state, state_next;

  logic [IDX_W-1:0] nr_m1, nk_m1, nc_m1;
  logic [IDX_W-1:0] ci, cj, ck;
  logic             last_i, last_j, last_k, stall, issue;

  mm_tag_t                    tag1, tag2;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [EXT_BITS-1:0]  prod_ext;
  logic [SUM_BITS-1:0]         acc, acc_sum;

  assign stall  = out_valid & ~out_ready;
  assign issue  = (state == ST_RUN) & ~stall;
  assign last_i = (ci == nr_m1);
  assign last_j = (cj == nc_m1);
  assign last_k = (ck == nk_m1);
  assign busy   = (state == ST_RUN);

  assign rd_en     = issue;
  assign rd_addr_a = ADDR_W'(32'(ci) * MAX_DIM + 32'(ck));
  assign rd_addr_b = ADDR_W'(32'(ck) * MAX_DIM + 32'(cj));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue && last_i && last_j && last_k) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ci <= '0;
      cj <= '0;
      ck <= '0;
    end else if (state == ST_IDLE && cmd.start) begin
      ci <= '0;
      cj <= '0;
      ck <= '0;
    end else if (issue) begin
      if (!last_k) begin
        ck <= ck + 1'b1;
      end else begin
        ck <= '0;
        if (!last_j) begin
          cj <= cj + 1'b1;
        end else begin
          cj <= '0;
          ci <= ci + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd.start) begin
      nr_m1 <= IDX_W'(cmd.rows_m1);
      nk_m1 <= IDX_W'(cmd.inner_m1);
      nc_m1 <= IDX_W'(cmd.cols_m1);
    end
  end

  // read stage tags, product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
    end else if (!stall) begin
      tag1.valid    <= issue;
      tag1.first    <= (ck == '0);
      tag1.last_k   <= last_k;
      tag1.last_out <= last_k & last_j & last_i;
      tag1.row      <= IDX_BITS'(ci);
      tag1.col      <= IDX_BITS'(cj);
      tag2          <= tag1;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      prod <= $signed(rd_data_a) * $signed(rd_data_b);
    end
  end

  assign prod_ext = EXT_BITS'(prod);
  assign acc_sum  = (tag2.first ? '0 : acc) + prod_ext[SUM_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!stall && tag2.valid) begin
      acc <= acc_sum;
      if (tag2.last_k) begin
        out_sum  <= acc_sum;
        out_row  <= tag2.row;
        out_col  <= tag2.col;
        out_last <= tag2.last_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!stall && tag2.valid && tag2.last_k) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: hw/rtl/matrix_multiply.sv
// matrix_multiply: streaming general matrix multiply, top level
// depends on mm_pkg, mm_ram and mm_engine
//
// usage:
//   slave stream: tuser carries the action, tdata the row, col and value.
//   a write A / write B transaction stores one element, one per cycle while idle.
//   a multiply transaction emits rows_a * cols_b results on the master
//   stream in row-major order, tlast on the final one.
//   the user sets sizes over the APB port while the block is idle (not enforced).
// timing:
//   a multiply walks every product, one per cycle unless the master stream stalls,
//   through one multiplier fed by the read ports of the two element memories
//   (sizes clamped to 1..MAX_DIM). each product passes the memory read register
//   and the product register into the accumulator; each result is registered
//   when its dot product ends. s_tready is low while the multiply issues reads,
//   so the next transaction waits until the last product is issued, longer
//   when the master stream stalls.
// reset:
//   sizes go to 4, no result is pending; element memories are not cleared.
// backpressure:
//   with m_tvalid high and m_tready low the whole pipeline holds.
module matrix_multiply
  import mm_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,   // row[2:0], col[5:3], value[21:6]
  input  logic [1:0]               s_tuser,   // action[1:0]
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata,   // out_row[2:0], out_col[5:3], sum[41:6]
  output logic                     m_tlast,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int ADDR_W = $clog2(MAX_DIM*MAX_DIM);
  localparam int VX_W   = (ELEM_BITS > VALUE_BITS) ? ELEM_BITS : VALUE_BITS;

  logic [CFG_BITS-1:0] rows_a, inner_size, cols_b;
  logic                cfg_wr;
  mm_reg_t             reg_sel;

  logic [IDX_BITS-1:0]          s_row, s_col;
  logic signed [VALUE_BITS-1:0] s_value;
  logic signed [VX_W-1:0]       value_ext;
  logic                         s_acc, in_range, we_a, we_b, busy;
  logic [ADDR_W-1:0]            waddr, rd_addr_a, rd_addr_b;
  logic [ELEM_BITS-1:0]         rd_data_a, rd_data_b;
  logic                         rd_en;
  mm_cmd_t                      cmd;
  logic [IDX_BITS-1:0]          out_row, out_col;
  logic [SUM_BITS-1:0]          out_sum;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_sel = mm_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= CFG_BITS'(4);
      inner_size <= CFG_BITS'(4);
      cols_b     <= CFG_BITS'(4);
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_ROWS_A:     rows_a     <= pwdata[CFG_BITS-1:0];
        REG_INNER_SIZE: inner_size <= pwdata[CFG_BITS-1:0];
        REG_COLS_B:     cols_b     <= pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ROWS_A:     prdata = APB_DATA_BITS'(rows_a);
      REG_INNER_SIZE: prdata = APB_DATA_BITS'(inner_size);
      REG_COLS_B:     prdata = APB_DATA_BITS'(cols_b);
      default:        prdata = '0;
    endcase
  end

  function automatic logic [CFG_BITS-1:0] size_m1(input logic [CFG_BITS-1:0] sz);
    logic [CFG_BITS-1:0] r;
    if (sz == '0) begin
      r = '0;
    end else if (32'(sz) > MAX_DIM) begin
      r = CFG_BITS'(MAX_DIM - 1);
    end else begin
      r = sz - 1'b1;
    end
    return r;
  endfunction

  // input decode
  assign s_row     = s_tdata[2:0];
  assign s_col     = s_tdata[5:3];
  assign s_value   = s_tdata[21:6];
  assign value_ext = VX_W'(s_value);
  assign s_tready  = ~busy;
  assign s_acc     = s_tvalid & s_tready;
  assign in_range  = (32'(s_row) < MAX_DIM) && (32'(s_col) < MAX_DIM);
  assign waddr     = ADDR_W'(32'(s_row) * MAX_DIM + 32'(s_col));
  assign we_a      = s_acc && in_range && (s_tuser == ACT_WRITE_A);
  assign we_b      = s_acc && in_range && (s_tuser == ACT_WRITE_B);

  assign cmd.start    = s_acc && (s_tuser == ACT_MULTIPLY);
  assign cmd.rows_m1  = size_m1(rows_a);
  assign cmd.inner_m1 = size_m1(inner_size);
  assign cmd.cols_m1  = size_m1(cols_b);

  mm_ram #(
    .WIDTH(ELEM_BITS),
    .DEPTH(MAX_DIM*MAX_DIM)
  ) u_ram_a (
    .clk  (clk),
    .we   (we_a),
    .waddr(waddr),
    .wdata(value_ext[ELEM_BITS-1:0]),
    .re   (rd_en),
    .raddr(rd_addr_a),
    .rdata(rd_data_a)
  );

  mm_ram #(
    .WIDTH(ELEM_BITS),
    .DEPTH(MAX_DIM*MAX_DIM)
  ) u_ram_b (
    .clk  (clk),
    .we   (we_b),
    .waddr(waddr),
    .wdata(value_ext[ELEM_BITS-1:0]),
    .re   (rd_en),
    .raddr(rd_addr_b),
    .rdata(rd_data_b)
  );

  mm_engine #(
    .MAX_DIM  (MAX_DIM),
    .ELEM_BITS(ELEM_BITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .busy     (busy),
    .rd_en    (rd_en),
    .rd_addr_a(rd_addr_a),
    .rd_addr_b(rd_addr_b),
    .rd_data_a(rd_data_a),
    .rd_data_b(rd_data_b),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_row  (out_row),
    .out_col  (out_col),
    .out_sum  (out_sum),
    .out_last (m_tlast)
  );

  assign m_tdata = {(OUT_DATA_BITS - SUM_BITS - 2*IDX_BITS)'(0), out_sum, out_col, out_row};

endmodule

// File: hw/rtl/mm_checker.sv
// mm_checker: port-level checks for matrix_multiply, bound to the top level
// depends on mm_pkg
module mm_checker
  import mm_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic [1:0]               s_tuser,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [OUT_DATA_BITS-1:0] m_tdata,
  input logic                     m_tlast,
  input logic                     pready
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // reset leaves the block ready with nothing pending
  a_reset: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("state after reset wrong");

  // a multiply start makes the input side busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == ACT_MULTIPLY) |=> !s_tready)
    else $error("input ready after start");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind matrix_multiply mm_checker u_mm_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast),
  .pready  (pready)
);

// File: bench/tb_matrix_multiply.sv
// tb_matrix_multiply: self-checking bench for the streaming matrix multiply
// loads A and B over the slave stream, sets sizes over APB and checks each
// result against an in-bench model; depends on mm_pkg and matrix_multiply
module tb_matrix_multiply;
  timeunit 1ns;
  timeprecision 1ps;
  import mm_pkg::*;

  localparam int DIM = MAX_DIM_DEF;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int TARGET_ITEMS = 270;

  typedef struct {
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
    logic [SUM_BITS-1:0] sum;
    logic                last;
  } product_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata = '0;  // row[2:0], col[5:3], value[21:6]
  logic [1:0]               s_tuser = '0;  // action[1:0]
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;       // out_row[2:0], out_col[5:3], sum[41:6]
  logic                     m_tlast;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  logic [VALUE_BITS-1:0] elem_a [DIM*DIM];
  logic [VALUE_BITS-1:0] elem_b [DIM*DIM];
  bit                    a_loaded [DIM*DIM];
  bit                    b_loaded [DIM*DIM];
  logic [CFG_BITS-1:0]   size_reg [3] = '{4'd4, 4'd4, 4'd4};
  product_t              results_due [$];
  int                    fails = 0;
  int                    items_sent = 0;
  int                    idle_cycles = 0;
  int                    rx_left = 0;
  bit                    quiet = 1'b0;

  matrix_multiply DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int eff_size(logic [CFG_BITS-1:0] s);
    if (s == 0) return 1;
    if (s > DIM) return DIM;
    return int'(s);
  endfunction

  function automatic logic [CFG_BITS-1:0] rand_size();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return CFG_BITS'($urandom_range(1, 3));
    if (r < 17) return CFG_BITS'($urandom_range(4, 8));
    if (r < 18) return '0;
    return CFG_BITS'($urandom_range(9, 15));
  endfunction

  function automatic logic [VALUE_BITS-1:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h8000;
    if (r < 20) return 16'h7fff;
    if (r < 25) return 16'h0000;
    if (r < 30) return 16'hffff;
    return VALUE_BITS'($urandom());
  endfunction

  function automatic void predict_products();
    int       nr, nk, nc;
    longint   acc;
    product_t p;
    nr = eff_size(size_reg[REG_ROWS_A]);
    nk = eff_size(size_reg[REG_INNER_SIZE]);
    nc = eff_size(size_reg[REG_COLS_B]);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = 0;
        for (int k = 0; k < nk; k++) begin
          acc += longint'($signed(elem_a[i*DIM+k])) * longint'($signed(elem_b[k*DIM+j]));
        end
        p.row  = IDX_BITS'(i);
        p.col  = IDX_BITS'(j);
        p.sum  = acc[SUM_BITS-1:0];
        p.last = (i == nr - 1) && (j == nc - 1);
        results_due.push_back(p);
      end
    end
  endfunction

  function automatic void apply_transaction(logic [1:0] action, logic [IDX_BITS-1:0] row,
                                            logic [IDX_BITS-1:0] col,
                                            logic [VALUE_BITS-1:0] value);
    case (action)
      ACT_WRITE_A: begin
        elem_a[row*DIM+col]   = value;
        a_loaded[row*DIM+col] = 1'b1;
      end
      ACT_WRITE_B: begin
        elem_b[row*DIM+col]   = value;
        b_loaded[row*DIM+col] = 1'b1;
      end
      ACT_MULTIPLY: predict_products();
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [1:0] action, logic [IDX_BITS-1:0] row,
                           logic [IDX_BITS-1:0] col, logic [VALUE_BITS-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= action;
    s_tdata  <= {2'b00, value, col, row};
    do @(posedge clk); while (!s_tready);
    apply_transaction(action, row, col, value);
    if (action != ACT_UNUSED) items_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_size(mm_reg_t idx, logic [CFG_BITS-1:0] size);
    logic [APB_DATA_BITS-1:0] data;
    data       = $urandom();
    data[3:0]  = size;
    s_tvalid  <= 1'b0;
    psel      <= 1'b1;
    penable   <= 1'b0;
    pwrite    <= 1'b1;
    paddr     <= {idx, 2'b00};
    pwdata    <= data;
    @(posedge clk);
    penable   <= 1'b1;
    @(posedge clk);
    size_reg[idx] = size;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    @(posedge clk);
    penable   <= 1'b1;
    @(posedge clk);
    if (prdata[CFG_BITS-1:0] !== size_reg[idx]) begin
      $error("prdata expected %0d actual %0d", size_reg[idx], prdata[CFG_BITS-1:0]);
      fails++;
    end
    psel      <= 1'b0;
    penable   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_sizes(logic [CFG_BITS-1:0] r, logic [CFG_BITS-1:0] k,
                           logic [CFG_BITS-1:0] c);
    wait_idle();
    write_size(REG_ROWS_A, r);
    write_size(REG_INNER_SIZE, k);
    write_size(REG_COLS_B, c);
  endtask

  // every element that the next multiply reads gets loaded first
  task automatic load_missing();
    int nr, nk, nc;
    nr = eff_size(size_reg[REG_ROWS_A]);
    nk = eff_size(size_reg[REG_INNER_SIZE]);
    nc = eff_size(size_reg[REG_COLS_B]);
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++)
        if (!a_loaded[i*DIM+k]) send_item(ACT_WRITE_A, IDX_BITS'(i), IDX_BITS'(k), rand_value());
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++)
        if (!b_loaded[k*DIM+j]) send_item(ACT_WRITE_B, IDX_BITS'(k), IDX_BITS'(j), rand_value());
  endtask

  task automatic noise_item();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) send_item(ACT_UNUSED, IDX_BITS'($urandom()), IDX_BITS'($urandom()),
                          VALUE_BITS'($urandom()));
    else if (r < 6) send_item(ACT_WRITE_A, IDX_BITS'($urandom()), IDX_BITS'($urandom()),
                              rand_value());
    else send_item(ACT_WRITE_B, IDX_BITS'($urandom()), IDX_BITS'($urandom()), rand_value());
  endtask

  task automatic start_multiply();
    send_item(ACT_MULTIPLY, IDX_BITS'($urandom()), IDX_BITS'($urandom()),
              VALUE_BITS'($urandom()));
  endtask

  task automatic test_directed();
    set_sizes(4'd2, 4'd2, 4'd2);
    send_item(ACT_WRITE_A, 3'd0, 3'd0, 16'h8000);
    send_item(ACT_WRITE_A, 3'd0, 3'd1, 16'h7fff);
    send_item(ACT_WRITE_A, 3'd1, 3'd0, 16'h0000);
    send_item(ACT_WRITE_A, 3'd1, 3'd1, 16'hffff);
    send_item(ACT_WRITE_B, 3'd0, 3'd0, 16'h8000);
    send_item(ACT_WRITE_B, 3'd0, 3'd1, 16'h8000);
    send_item(ACT_WRITE_B, 3'd1, 3'd0, 16'h7fff);
    send_item(ACT_WRITE_B, 3'd1, 3'd1, 16'h0001);
    send_item(ACT_UNUSED, 3'd7, 3'd7, 16'hffff);
    send_item(ACT_MULTIPLY, 3'd0, 3'd0, 16'h0000);
    send_item(ACT_WRITE_A, 3'd7, 3'd7, 16'h7fff);
    send_item(ACT_WRITE_B, 3'd7, 3'd7, 16'h8000);
    send_item(ACT_MULTIPLY, 3'd7, 3'd7, 16'hffff);
    set_sizes(4'd1, 4'd1, 4'd1);
    send_item(ACT_MULTIPLY, 3'd0, 3'd0, 16'h0000);
  endtask

  task automatic test_size_clamp();
    set_sizes(4'd0, 4'd0, 4'd0);
    start_multiply();
    set_sizes(4'd15, 4'd15, 4'd15);
    load_missing();
    start_multiply();
    set_sizes(4'd8, 4'd0, 4'd15);
    load_missing();
    start_multiply();
  endtask

  task automatic test_no_idle();
    quiet = 1'b1;
    set_sizes(4'd3, 4'd2, 4'd3);
    repeat (4) noise_item();
    load_missing();
    start_multiply();
    start_multiply();
    send_item(ACT_WRITE_A, 3'd2, 3'd1, rand_value());
    start_multiply();
    wait_idle();
    quiet = 1'b0;
  endtask

  task automatic test_random_runs();
    while (items_sent < TARGET_ITEMS) begin
      set_sizes(rand_size(), rand_size(), rand_size());
      repeat ($urandom_range(0, 6)) noise_item();
      load_missing();
      start_multiply();
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) noise_item();
        load_missing();
        start_multiply();
      end
    end
  endtask

  always @(posedge clk) begin : rx_pace
    int g;
    if (rx_left > 0) begin
      rx_left <= rx_left - 1;
    end else begin
      g = pick_gap();
      if (g == 0) begin
        m_tready <= 1'b1;
        rx_left  <= $urandom_range(0, 6);
      end else begin
        m_tready <= 1'b0;
        rx_left  <= g - 1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    product_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        $error("result with no expectation: out_row %0d out_col %0d",
               m_tdata[2:0], m_tdata[5:3]);
        fails++;
      end else begin
        want = results_due.pop_front();
        if (m_tdata[2:0] !== want.row) begin
          $error("out_row expected %0d actual %0d", want.row, m_tdata[2:0]);
          fails++;
        end
        if (m_tdata[5:3] !== want.col) begin
          $error("out_col expected %0d actual %0d", want.col, m_tdata[5:3]);
          fails++;
        end
        if (m_tdata[41:6] !== want.sum) begin
          $error("sum expected %0d actual %0d", $signed(want.sum), $signed(m_tdata[41:6]));
          fails++;
        end
        if (m_tlast !== want.last) begin
          $error("last expected %0d actual %0d", want.last, m_tlast);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** matrix_multiply: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_size_clamp();
    test_no_idle();
    test_random_runs();
    wait_idle();
    repeat (20) @(posedge clk);
    if (fails == 0 && results_due.size() == 0) begin
      $display("** matrix_multiply: PASSED **");
    end else begin
      $display("** matrix_multiply: FAILED **");
    end
    $finish;
  end

endmodule
